// ===== src/swmm_pkg.sv =====
// shared constants and types for the sliding window min/max/mean block
package swmm_pkg;

  localparam int SAMPLE_W             = 24;
  localparam int SECONDS_W            = 5;
  localparam int WINDOW_SECONDS_RESET = 10;
  localparam int MAX_LEN_DEFAULT      = 2048;
  localparam int SPS_DEFAULT          = 60;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REFILL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } swmm_state_t;

endpackage

// ===== src/sliding_window_min_max_mean_top.sv =====
// Sliding window min/max/mean: a history ram of recent samples, scanned per transaction.
// Input channel (in_valid / in_stall) carries op and sample. op push writes the sample at
// the head of a circular history of MAX_LEN entries and scans the newest L entries, where
// L = max(window_seconds,1) * SAMPLES_PER_SECOND clamped to MAX_LEN. op refill writes the
// sample into every entry and leaves the head where it is.
// Output channel (out_valid / out_stall) gives min_value, max_value, avg_value (sum / L
// truncated toward zero) and newest_value, one result per input transaction.
// A push runs in steps: a scan of the L entries at one ram read per cycle, a divider that
// gives one of its SUM_W quotient bits per cycle, where SUM_W = 24 + bits of MAX_LEN, and
// the load of the output register. A refill writes one ram entry per cycle, then gives its result.
// One transaction is in work at a time; in_stall is high while it is processed. The result
// sits in an output register, so the next input is taken while it waits to be read.
// Reset (rst, synchronous) sets window_seconds to 10, the head to zero, and starts a
// clearing pass over all MAX_LEN entries that writes zeros to the history; in_stall stays high
// during it. window_seconds is written through cfg_we / cfg_data at any time, and should
// only change while no transaction is in flight.
// When out_stall is high the result holds, and a finished transaction waits for the slot.
module sliding_window_min_max_mean_top #(
  parameter int MAX_LEN            = swmm_pkg::MAX_LEN_DEFAULT,
  parameter int SAMPLES_PER_SECOND = swmm_pkg::SPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swmm_pkg::SECONDS_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] min_value,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] max_value,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] avg_value,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] newest_value
);

  localparam int SW     = swmm_pkg::SAMPLE_W;
  localparam int SEC_W  = swmm_pkg::SECONDS_W;
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int PROD_W = SEC_W + $clog2(SAMPLES_PER_SECOND + 1);
  localparam int CMP_W  = (PROD_W > LEN_W) ? PROD_W : LEN_W;
  localparam int SUM_W  = SW + LEN_W;

  swmm_pkg::swmm_state_t state, state_next;

  logic [SEC_W-1:0]     window_seconds;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     cnt;
  logic [IDX_W-1:0]     rd_idx;
  logic [LEN_W-1:0]     issue_left;
  logic [LEN_W-1:0]     len_q;
  logic                 rd_vld;
  logic signed [SW-1:0] fill_data;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] avg;
  logic signed [SW-1:0] newest;
  logic signed [SUM_W-1:0] sum;

  logic                 in_acc;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [SW-1:0]        ram_rdata;
  logic signed [SW-1:0] rd_s;
  logic                 div_start;
  logic                 div_done;
  logic signed [SUM_W-1:0] quotient;
  logic                 out_load;
  logic                 cnt_last;

  logic [SEC_W-1:0]     secs;
  logic [PROD_W-1:0]    prod;
  logic [LEN_W-1:0]     len_cur;

  // window length from the seconds register
  always_comb begin
    secs    = (window_seconds == '0) ? SEC_W'(1) : window_seconds;
    prod    = PROD_W'(secs) * PROD_W'(SAMPLES_PER_SECOND);
    len_cur = (CMP_W'(prod) > CMP_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(prod);
  end

  assign cnt_last = (cnt == IDX_W'(MAX_LEN - 1));
  assign in_stall = (state != swmm_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rd_s     = $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = fill_data;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      swmm_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_last) begin
          state_next = swmm_pkg::ST_IDLE;
        end
      end
      swmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (op == swmm_pkg::OP_REFILL) begin
            state_next = swmm_pkg::ST_FILL;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = head;
            ram_wdata  = sample;
            state_next = swmm_pkg::ST_SCAN;
          end
        end
      end
      swmm_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (cnt_last) begin
          state_next = swmm_pkg::ST_DONE;
        end
      end
      swmm_pkg::ST_SCAN: begin
        ram_re = (issue_left != '0);
        if (issue_left == '0 && !rd_vld) begin
          div_start  = 1'b1;
          state_next = swmm_pkg::ST_DIV;
        end
      end
      swmm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = swmm_pkg::ST_DONE;
        end
      end
      swmm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= SEC_W'(swmm_pkg::WINDOW_SECONDS_RESET);
      head           <= '0;
      cnt            <= '0;
      fill_data      <= '0;
      rd_vld         <= 1'b0;
      issue_left     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_seconds <= cfg_data;
      end
      rd_vld <= ram_re;

      if (state == swmm_pkg::ST_CLEAR || state == swmm_pkg::ST_FILL) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end

      if (in_acc) begin
        newest <= sample;
        lo     <= sample;
        hi     <= sample;
        avg    <= sample;
        if (op == swmm_pkg::OP_REFILL) begin
          fill_data <= sample;
        end else begin
          head       <= (head == IDX_W'(MAX_LEN - 1)) ? '0 : head + 1'b1;
          rd_idx     <= head;
          issue_left <= len_cur;
          len_q      <= len_cur;
          sum        <= '0;
        end
      end

      // walk back from the newest entry, one read per cycle
      if (ram_re) begin
        rd_idx     <= (rd_idx == '0) ? IDX_W'(MAX_LEN - 1) : rd_idx - 1'b1;
        issue_left <= issue_left - 1'b1;
      end
      if (rd_vld) begin
        if (rd_s < lo) begin
          lo <= rd_s;
        end
        if (rd_s > hi) begin
          hi <= rd_s;
        end
        sum <= sum + {{(SUM_W - SW){rd_s[SW-1]}}, rd_s};
      end

      if (div_done) begin
        avg <= quotient[SW-1:0];
      end

      if (out_load) begin
        out_valid    <= 1'b1;
        min_value    <= lo;
        max_value    <= hi;
        avg_value    <= avg;
        newest_value <= newest;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  swmm_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_LEN)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  swmm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (len_q),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== src/swmm_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module swmm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/swmm_div.sv =====
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module swmm_div #(
  parameter int DIVIDEND_W = 36,
  parameter int DIVISOR_W  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DIVISOR_W-1:0]  divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  active;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic [DIVIDEND_W-1:0] q;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;

  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    diff;
  logic [DIVIDEND_W-1:0] mag;

  always_comb begin
    trial = {rem, q[DIVIDEND_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
    mag   = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == CNT_W'(1));
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(DIVIDEND_W);
        neg    <= dividend[DIVIDEND_W-1];
        q      <= mag;
        rem    <= '0;
        dvs    <= divisor;
      end else if (active) begin
        // restoring step: the shifted-out dividend bit meets the remainder
        rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        q   <= {q[DIVIDEND_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);

endmodule

// ===== dv/sliding_window_min_max_mean_top_tb.sv =====
// testbench for the sliding window min/max/mean block: directed table, random phases, scoreboard
module sliding_window_min_max_mean_top_tb;

  localparam int SAMPLE_W    = swmm_pkg::SAMPLE_W;
  localparam int SECONDS_W   = swmm_pkg::SECONDS_W;
  localparam int HIST_DEPTH  = swmm_pkg::MAX_LEN_DEFAULT;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_WAIT = 2100;
  localparam int NUM_PHASES  = 7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] newest;
  } window_stats_t;

  typedef struct packed {
    logic                is_cfg;
    logic                op;
    logic [SAMPLE_W-1:0] val;
    logic                typed;
    logic [SAMPLE_W-1:0] want;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [SECONDS_W-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] min_value;
  logic signed [SAMPLE_W-1:0] max_value;
  logic signed [SAMPLE_W-1:0] avg_value;
  logic signed [SAMPLE_W-1:0] newest_value;

  // shadow of the block: history, head and window setting
  logic signed [SAMPLE_W-1:0] sample_hist [HIST_DEPTH];
  int unsigned                hist_head;
  logic [SECONDS_W-1:0]       win_secs;

  window_stats_t pending_stats[$];
  stim_row_t     directed[$];
  int            mismatches;
  int            quiet_count;
  int            hold_len;
  bit            calm;

  sliding_window_min_max_mean_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .min_value    (min_value),
    .max_value    (max_value),
    .avg_value    (avg_value),
    .newest_value (newest_value)
  );

  always #5 clk = ~clk;

  function automatic window_stats_t window_stats_after(input logic o,
                                                       input logic signed [SAMPLE_W-1:0] s);
    window_stats_t              st;
    int unsigned                secs;
    int unsigned                len;
    int unsigned                idx;
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    longint                     acc;
    longint                     avg;
    if (o == swmm_pkg::OP_REFILL) begin
      for (int i = 0; i < HIST_DEPTH; i++) sample_hist[i] = s;
      st.lo = s;
      st.hi = s;
      st.mean = s;
      st.newest = s;
      return st;
    end
    secs = (win_secs == 0) ? 1 : win_secs;
    len = secs * swmm_pkg::SPS_DEFAULT;
    if (len > HIST_DEPTH) len = HIST_DEPTH;
    sample_hist[hist_head] = s;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    lo = s;
    hi = s;
    acc = 0;
    idx = hist_head;
    for (int i = 0; i < len; i++) begin
      idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
      v = sample_hist[idx];
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      acc += v;
    end
    avg = acc / longint'(len);
    st.lo = lo;
    st.hi = hi;
    st.mean = avg[SAMPLE_W-1:0];
    st.newest = s;
    return st;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return SAMPLE_W'($urandom_range(0, 512) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic add_row(input logic is_cfg, input logic o, input logic [SAMPLE_W-1:0] val,
                         input logic typed, input logic [SAMPLE_W-1:0] want);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.op = o;
    r.val = val;
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endtask

  // present one transaction and hold it until it is taken
  task automatic offer(input logic o, input logic [SAMPLE_W-1:0] s,
                       input logic typed, input logic [SAMPLE_W-1:0] want);
    window_stats_t st;
    in_valid <= 1'b1;
    op <= o;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    st = window_stats_after(o, s);
    if (typed) st = {want, want, want, want};
    pending_stats.push_back(st);
  endtask

  task automatic rest(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(input logic [SECONDS_W-1:0] secs);
    cfg_we <= 1'b1;
    cfg_data <= secs;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_secs = secs;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // scoreboard
  always @(posedge clk) begin : result_check
    window_stats_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: result with no transaction pending, min %0d max %0d avg %0d new %0d",
                 $time, min_value, max_value, avg_value, newest_value);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("min_value", want.lo, min_value);
        check_field("max_value", want.hi, max_value);
        check_field("avg_value", want.mean, avg_value);
        check_field("newest_value", want.newest, newest_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // receiver back-pressure: short bursts, quiet stretches, and one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (!calm) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            out_stall <= 1'b0;
          end
          4: repeat ($urandom_range(30, 100)) @(posedge clk);
          default: ;
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase_secs [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int secs;
    stim_row_t r;
    phase_secs = '{1, 0, 31, 2, 3, 20, 1};
    phase_items = '{110, 70, 15, 100, 25, 20, 92};
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = swmm_pkg::OP_PUSH;
    sample = '0;
    mismatches = 0;
    quiet_count = 0;
    hold_len = 0;
    calm = 1'b0;
    for (int i = 0; i < HIST_DEPTH; i++) sample_hist[i] = '0;
    hist_head = 0;
    win_secs = SECONDS_W'(swmm_pkg::WINDOW_SECONDS_RESET);

    // directed table; typed expectations only where the answer is obvious
    add_row(0, swmm_pkg::OP_PUSH,   24'h000000, 1, 24'h000000);  // history is all zeros after reset
    add_row(0, swmm_pkg::OP_PUSH,   24'h7FFFFF, 0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'h800000, 0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'hFFFFFF, 0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'h555555, 0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'hAAAAAA, 0, '0);
    add_row(0, swmm_pkg::OP_REFILL, 24'h800000, 1, 24'h800000);
    add_row(0, swmm_pkg::OP_PUSH,   24'h800000, 1, 24'h800000);
    add_row(0, swmm_pkg::OP_PUSH,   24'h7FFFFF, 0, '0);
    add_row(0, swmm_pkg::OP_REFILL, 24'h7FFFFF, 1, 24'h7FFFFF);
    add_row(0, swmm_pkg::OP_PUSH,   24'h7FFFFF, 1, 24'h7FFFFF);
    add_row(1, swmm_pkg::OP_PUSH,   24'd0,      0, '0);          // zero seconds acts as one
    add_row(0, swmm_pkg::OP_PUSH,   24'hFFFFFF, 0, '0);
    add_row(0, swmm_pkg::OP_REFILL, 24'h000000, 1, 24'h000000);
    add_row(0, swmm_pkg::OP_PUSH,   24'hFFFFFF, 0, '0);          // mean of -1 / 60 is zero
    add_row(0, swmm_pkg::OP_PUSH,   24'h000001, 0, '0);
    add_row(1, swmm_pkg::OP_PUSH,   24'd31,     0, '0);          // longer window, no refill
    add_row(0, swmm_pkg::OP_PUSH,   24'h000100, 0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'hFFFF00, 0, '0);
    add_row(1, swmm_pkg::OP_PUSH,   24'd2,      0, '0);
    add_row(0, swmm_pkg::OP_PUSH,   24'h000064, 0, '0);
    add_row(0, swmm_pkg::OP_REFILL, 24'hFFFFFF, 1, 24'hFFFFFF);
    add_row(0, swmm_pkg::OP_PUSH,   24'hFFFFFF, 1, 24'hFFFFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      r = directed[k];
      if (r.is_cfg) begin
        drain();
        set_window(r.val[SECONDS_W-1:0]);
      end else begin
        offer(r.op, r.val, r.typed, r.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      secs = (p == 4) ? $urandom_range(3, 30) : phase_secs[p];
      if (p == NUM_PHASES - 1) calm = 1'b1;
      drain();
      set_window(secs[SECONDS_W-1:0]);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 40) begin
          // long receiver hold while transactions keep coming, to back up the input
          hold_len = 600;
          repeat (8) offer(swmm_pkg::OP_PUSH, rand_sample(), 0, '0);
        end
        if (!calm && $urandom_range(0, 3) == 0) rest($urandom_range(1, 6));
        offer(($urandom_range(0, 19) == 0) ? swmm_pkg::OP_REFILL : swmm_pkg::OP_PUSH,
              rand_sample(), 0, '0);
      end
    end

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/swmm_pkg.sv
src/swmm_ram.sv
src/swmm_div.sv
src/sliding_window_min_max_mean_top.sv
dv/sliding_window_min_max_mean_top_tb.sv
